### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### hdl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Word types, character constants and the alphabet mapping of the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

	localparam logic [6:0] PAD_CHAR   = 7'd61;  // '='
	localparam logic [6:0] UPPER_BASE = 7'd65;  // 'A'
	localparam logic [6:0] LOWER_BASE = 7'd97;  // 'a'
	localparam logic [6:0] DIGIT_BASE = 7'd48;  // '0'
	localparam logic [6:0] PLUS_CHAR  = 7'd43;  // '+'
	localparam logic [6:0] DASH_CHAR  = 7'd45;  // '-'

	localparam logic [5:0] IDX_LOWER = 6'd26;
	localparam logic [5:0] IDX_DIGIT = 6'd52;
	localparam logic [5:0] IDX_PLUS  = 6'd62;
	localparam logic [5:0] IDX_DASH  = 6'd63;

	localparam logic [1:0] LAST_SLOT = 2'd3;
	localparam logic [1:0] FULL_CNT  = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} in_word_t;

	typedef struct packed {
		logic [6:0] code_char;
		logic       final_char;
	} out_word_t;

	// One assembled 24-bit group on its way to the serializer.
	typedef struct packed {
		logic [23:0] bytes;
		logic [1:0]  have;   // real bytes in the group, 1 to 3
		logic        last;
	} grp_t;

	function automatic logic [6:0] enc_char(input logic [5:0] idx);
		logic [6:0] c;
		if (idx < IDX_LOWER) begin
			c = UPPER_BASE + 7'(idx);
		end else if (idx < IDX_DIGIT) begin
			c = LOWER_BASE + 7'(idx - IDX_LOWER);
		end else if (idx < IDX_PLUS) begin
			c = DIGIT_BASE + 7'(idx - IDX_DIGIT);
		end else if (idx == IDX_PLUS) begin
			c = PLUS_CHAR;
		end else begin
			c = DASH_CHAR;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### hdl/b64e_group.sv
// ----------------------------------------------------------------------------
// b64e_group
// Collects message bytes into 24-bit groups and registers each finished group.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_group (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              data_valid,
	output logic                   data_stall,
	input  wire b64e_pkg::in_word_t data_word,
	output logic                   grp_valid,
	input  wire logic              grp_stall,
	output b64e_pkg::grp_t         grp_word
);

	logic [15:0]    pend_q;
	logic [1:0]     pend_cnt_q;
	logic           grp_valid_s1;
	b64e_pkg::grp_t grp_s1;

	logic        accept;
	logic        emit;
	logic [23:0] bytes;

	// A held group blocks new words only while the serializer cannot take it.
	assign data_stall = grp_valid_s1 && grp_stall;
	assign accept     = data_valid && !data_stall;
	assign emit       = data_word.end_of_message || (pend_cnt_q == b64e_pkg::FULL_CNT);

	always_comb begin
		unique case (pend_cnt_q)
			2'd0:    bytes = {data_word.data_byte, 16'h0000};
			2'd1:    bytes = {pend_q[15:8], data_word.data_byte, 8'h00};
			default: bytes = {pend_q, data_word.data_byte};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			pend_cnt_q   <= '0;
			grp_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (emit) begin
					pend_q     <= '0;
					pend_cnt_q <= '0;
				end else begin
					pend_q     <= bytes[23:8];
					pend_cnt_q <= pend_cnt_q + 2'd1;
				end
			end
			// A new group may replace the one leaving in the same cycle.
			if (accept && emit) begin
				grp_valid_s1 <= 1'b1;
			end else if (!grp_stall) begin
				grp_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			grp_s1.bytes <= bytes;
			grp_s1.have  <= pend_cnt_q + 2'd1;
			grp_s1.last  <= data_word.end_of_message;
		end
	end

	assign grp_valid = grp_valid_s1;
	assign grp_word  = grp_s1;

`include "assert_macros.svh"

	`ASSERT_IMPL(a_cnt_range, 1'b1, pend_cnt_q != 2'd3)
	`ASSERT_NEXT(a_emit_loads, accept && emit, grp_valid_s1 && (pend_cnt_q == 2'd0))
	`ASSERT_NEXT(a_grp_holds, grp_valid_s1 && grp_stall, grp_valid_s1 && $stable(grp_s1))

endmodule

`default_nettype wire

### hdl/b64e_serial.sv
// ----------------------------------------------------------------------------
// b64e_serial
// Turns one group into four characters, one per cycle unless the output stalls, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_serial (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               grp_valid,
	output logic                    grp_stall,
	input  wire b64e_pkg::grp_t     grp_word,
	output logic                    code_valid,
	input  wire logic               code_stall,
	output b64e_pkg::out_word_t     code_word
);

	b64e_pkg::grp_t      cur_q;
	logic                busy_q;
	logic [1:0]          slot_q;
	logic                out_valid_q;
	b64e_pkg::out_word_t out_q;

	logic       adv;
	logic       grp_take;
	logic [5:0] idx;
	logic [6:0] chr;

	assign adv       = busy_q && (!out_valid_q || !code_stall);
	assign grp_take  = grp_valid && (!busy_q || (adv && (slot_q == b64e_pkg::LAST_SLOT)));
	assign grp_stall = !grp_take;

	always_comb begin
		unique case (slot_q)
			2'd0:    idx = cur_q.bytes[23:18];
			2'd1:    idx = cur_q.bytes[17:12];
			2'd2:    idx = cur_q.bytes[11:6];
			default: idx = cur_q.bytes[5:0];
		endcase
		// Slots past the real characters are padding.
		chr = (slot_q <= cur_q.have) ? b64e_pkg::enc_char(idx) : b64e_pkg::PAD_CHAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !code_stall) begin
				out_valid_q <= 1'b0;
			end
			// A new group starts over at the first slot, even as the old one ends.
			if (grp_take) begin
				busy_q <= 1'b1;
				slot_q <= '0;
			end else if (adv) begin
				slot_q <= slot_q + 2'd1;
				if (slot_q == b64e_pkg::LAST_SLOT) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_take) begin
			cur_q <= grp_word;
		end
		if (adv) begin
			out_q.code_char  <= chr;
			out_q.final_char <= cur_q.last && (slot_q == b64e_pkg::LAST_SLOT);
		end
	end

	assign code_valid = out_valid_q;
	assign code_word  = out_q;

`include "assert_macros.svh"

	`ASSERT_NEXT(a_take_starts, grp_take, busy_q && (slot_q == 2'd0))
	`ASSERT_NEXT(a_adv_fills, adv, out_valid_q)
	`ASSERT_NEXT(a_group_ends, adv && (slot_q == b64e_pkg::LAST_SLOT) && !grp_take, !busy_q)

endmodule

`default_nettype wire

### hdl/base64_stream_encoder.sv
// Path: the byte completing a group passes the group register, then the serializer's
// group register, and its first character is then valid in the output register.
// Throughput: one character per cycle unless the output stalls; each group gives four
// characters, and the serializer takes the next group as the current one ends.
// Reset: arst_n clears the pending bytes and count and the valid flags of all stages.
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder: bytes in, alphabet characters and padding out.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                data_valid,
	output logic                     data_stall,
	input  wire b64e_pkg::in_word_t  data_word,
	output logic                     code_valid,
	input  wire logic                code_stall,
	output b64e_pkg::out_word_t      code_word
);

	// The byte word flows into the group collector. Up to two bytes wait there;
	// the third byte, or any byte marked as the end of the message, closes a
	// group, which is held in a one-entry group register.
	logic           grp_valid;
	logic           grp_stall;
	b64e_pkg::grp_t grp_word;

	b64e_group u_group (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data_word  (data_word),
		.grp_valid  (grp_valid),
		.grp_stall  (grp_stall),
		.grp_word   (grp_word)
	);

	// The serializer takes a group when idle or as its previous one leaves its last
	// character, cuts it into four 6-bit indices, most significant first, and
	// maps each through the alphabet. Slots past the real characters carry the
	// padding character, and the fourth character of the closing group is
	// marked as the final one of the message.
	b64e_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.grp_valid  (grp_valid),
		.grp_stall  (grp_stall),
		.grp_word   (grp_word),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_word  (code_word)
	);

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming Base64 encoder. Byte messages go in,
// a scoreboard predicts each character and its final mark, and every
// character that leaves the block is compared against the oldest prediction.
// ----------------------------------------------------------------------------

// Scoreboard for the encoder. It keeps its own copy of the bytes waiting for
// a group to complete and the queue of characters that are still due.
class char_scoreboard;
	b64e_pkg::out_word_t due_chars[$];
	logic [15:0]         held_bytes;
	logic [1:0]          held_count;
	int                  mismatches;
	int                  bytes_taken;
	int                  chars_seen;
	int                  messages_done;

	function new();
		held_bytes    = '0;
		held_count    = '0;
		mismatches    = 0;
		bytes_taken   = 0;
		chars_seen    = 0;
		messages_done = 0;
	endfunction

	// Maps a 6-bit index onto the character set, dash standing in for slash.
	function logic [6:0] sextet_char(input logic [5:0] idx);
		string symbols;
		byte   ch;
		symbols = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz",
			"0123456789+-"};
		ch = symbols[idx];
		return ch[6:0];
	endfunction

	task report(input string what);
		if (mismatches < 100) begin
			$display("%0t ns: mismatch: %s", $time, what);
		end
		mismatches++;
	endtask

	// Called once per accepted input word.
	function void note_byte(input b64e_pkg::in_word_t w);
		logic [23:0]         group;
		int                  have;
		b64e_pkg::out_word_t c;
		bytes_taken++;
		have = int'(held_count) + 1;
		case (have)
			1: begin
				group = {w.data_byte, 16'h0000};
			end
			2: begin
				group = {held_bytes[15:8], w.data_byte, 8'h00};
			end
			default: begin
				group = {held_bytes, w.data_byte};
			end
		endcase
		if (have < 3 && !w.end_of_message) begin
			if (have == 1) begin
				held_bytes = {w.data_byte, 8'h00};
			end else begin
				held_bytes = {held_bytes[15:8], w.data_byte};
			end
			held_count = 2'(have);
			return;
		end
		// A group of n real bytes carries n+1 real characters; the rest of
		// the four slots are padding.
		for (int k = 0; k < 4; k++) begin
			c.code_char  = (k <= have) ? sextet_char(group[23 - 6 * k -: 6])
				: b64e_pkg::PAD_CHAR;
			c.final_char = w.end_of_message && (k == 3);
			due_chars.push_back(c);
		end
		if (w.end_of_message) begin
			messages_done++;
		end
		held_bytes = '0;
		held_count = '0;
	endfunction

	// Called once per accepted output word.
	task check_char(input b64e_pkg::out_word_t got);
		b64e_pkg::out_word_t want;
		chars_seen++;
		if (due_chars.size() == 0) begin
			report($sformatf("character %0d arrived with nothing due", got.code_char));
			return;
		end
		want = due_chars.pop_front();
		if (got.code_char !== want.code_char) begin
			report($sformatf("code_char %0d, predicted %0d", got.code_char,
				want.code_char));
		end
		if (got.final_char !== want.final_char) begin
			report($sformatf("final_char %0b, predicted %0b on character %0d",
				got.final_char, want.final_char, want.code_char));
		end
	endtask
endclass

module testbench;

	// Rough byte budget of the random part of each pacing phase.
	localparam int PHASE_BYTES = 69;
	// Cycles the drain at the end may take before leftovers count as lost.
	localparam int DRAIN_LIMIT = 4000;

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                data_valid = 1'b0;
	logic                data_stall;
	b64e_pkg::in_word_t  data_word  = '0;
	logic                code_valid;
	logic                code_stall = 1'b0;
	b64e_pkg::out_word_t code_word;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int send_idle_pct = 0;
	int stall_pct     = 0;

	char_scoreboard sb = new();

	base64_stream_encoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data_word  (data_word),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_word  (code_word)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop far beyond the slowest correct run, even with
	// heavy idling on both sides.
	initial begin
		#400000;
		$display("testbench NOT OK");
		$finish;
	end

	// The receiver stalls at random, one decision per cycle, changing only on
	// the falling edge so the DUT sees a settled value at every rising edge.
	initial begin
		forever begin
			@(negedge clk);
			code_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Both channels are observed at the rising edge. Signals the DUT drives
	// still hold their pre-edge values here, which is what the handshake
	// rule is defined on. The input side is noted first; its characters can
	// only show up cycles later anyway.
	always @(posedge clk) begin
		if (arst_n && data_valid && !data_stall) begin
			sb.note_byte(data_word);
		end
		if (arst_n && code_valid && !code_stall) begin
			sb.check_char(code_word);
		end
	end

	// Presents one word and holds it until the DUT takes it. Any idle cycles
	// come before the word is raised, so valid never reacts to stall and the
	// payload stays put while stalled. Returns at the falling edge after the
	// accepting edge with valid still high; the next word or its idle cycles
	// replace it there, and the caller lowers valid after the last word.
	task send_byte(input logic [7:0] value, input logic last);
		b64e_pkg::in_word_t w;
		w.data_byte      = value;
		w.end_of_message = last;
		while ($urandom_range(99) < send_idle_pct) begin
			data_valid <= 1'b0;
			@(negedge clk);
		end
		data_valid <= 1'b1;
		data_word  <= w;
		do begin
			@(posedge clk);
		end while (data_stall !== 1'b0);
		@(negedge clk);
	endtask

	// Sends a whole message; the final byte carries the end mark.
	task send_message(input logic [7:0] msg[$]);
		foreach (msg[i]) begin
			send_byte(msg[i], i == msg.size() - 1);
		end
	endtask

	// Random message of the given length. Roughly one byte in eight is forced
	// to all zeros or all ones so the extreme indices keep coming up.
	task send_random_message(input int len);
		logic [7:0] msg[$];
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(7) == 0) begin
				b = $urandom_range(1) ? 8'hff : 8'h00;
			end else begin
				b = 8'($urandom_range(255));
			end
			msg.push_back(b);
		end
		send_message(msg);
	endtask

	initial begin
		logic [7:0] msg[$];
		int         phase_start;
		int         len;
		int         waited;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed messages, no idling. A lone byte at both extremes (two
		// characters and double padding), two bytes (single padding), three
		// bytes that end exactly on a group, groups made of index 62 and of
		// index 63 only, and longer messages that end one and two bytes past
		// a full group.
		msg = {8'h00};                          send_message(msg);
		msg = {8'hff};                          send_message(msg);
		msg = {8'hff, 8'hff};                   send_message(msg);
		msg = {8'hff, 8'hff, 8'hff};            send_message(msg);
		msg = {8'hfb, 8'hef, 8'hbe};            send_message(msg);
		msg = {8'h4d, 8'h61, 8'h6e, 8'h41};     send_message(msg);
		msg = {8'h01, 8'h02, 8'h04, 8'h08, 8'h10};
		send_message(msg);
		msg = {8'h80, 8'h7f};                   send_message(msg);

		// Random messages over four pacing phases: free flowing, a slow
		// sender, a slow receiver, and light idling on both sides. Lengths
		// are mostly short so every group phase and every kind of ending
		// comes up often; now and then a long message runs many groups.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 59;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 59;
				end
				default: begin
					send_idle_pct = 9;
					stall_pct     = 9;
				end
			endcase
			phase_start = sb.bytes_taken;
			while (sb.bytes_taken - phase_start < PHASE_BYTES) begin
				if ($urandom_range(9) == 0) begin
					len = $urandom_range(10, 20);
				end else begin
					len = $urandom_range(1, 7);
				end
				send_random_message(len);
			end
		end
		data_valid <= 1'b0;

		// Drain: wait for every predicted character, then go on waiting so that any
		// stray extra character would still be caught.
		waited = 0;
		while (sb.due_chars.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (10) @(negedge clk);
		if (sb.due_chars.size() != 0) begin
			sb.report($sformatf("%0d predicted characters never arrived",
				sb.due_chars.size()));
		end

		$display("Encoded %0d bytes in %0d messages into %0d characters,",
			sb.bytes_taken, sb.messages_done, sb.chars_seen);
		$display("under free flow, slow sender, slow receiver and mixed pacing.");
		if (sb.mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
